// ===== hdl/snow_style_keystream_xor_assert.svh =====
// Assertion macros for the keystream XOR block.
// Included by the top level; assumes clk and arst_n are in scope.
`ifndef SNOW_STYLE_KEYSTREAM_XOR_ASSERT_SVH
`define SNOW_STYLE_KEYSTREAM_XOR_ASSERT_SVH

// Plain property, sampled on clk, off during reset.
`define SNOWKX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication to the next cycle.
`define SNOWKX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/snowkx_pkg.sv =====
// Shared types, register codes and substitution table for the keystream XOR block.
// No dependencies; used by snowkx_word_gen and snow_style_keystream_xor.
package snowkx_pkg;

	localparam int unsigned CELL_COUNT = 16;

	typedef logic [CELL_COUNT-1:0][31:0] cells_t;

	// result of one keystream word step
	typedef struct packed {
		logic [31:0] word;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] feed;
	} gen_t;

	// register word indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2
	} reg_idx_t;

	localparam logic CMD_RELOAD  = 1'b0;
	localparam logic CMD_ENCRYPT = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [31:0] sub_word(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

endpackage

// ===== hdl/snowkx_word_gen.sv =====
// Keystream word generator: one combinational step of FSM and shift register.
// Depends on snowkx_pkg (cells_t, gen_t, sub_word).
module snowkx_word_gen (
	input  snowkx_pkg::cells_t cells,
	input  logic [31:0]        r1,
	input  logic [31:0]        r2,
	output snowkx_pkg::gen_t   gen
);

	logic [31:0] f;
	logic [31:0] g;
	logic [31:0] taps;

	always_comb begin
		f        = (cells[15] + r1) ^ r2;
		g        = f + r2;
		taps     = cells[0] ^ cells[2] ^ cells[11] ^ cells[15];
		gen.word = f ^ cells[0];
		gen.r1   = r1 ^ {g[24:0], g[31:25]};
		gen.r2   = snowkx_pkg::sub_word(r1);
		gen.feed = {taps[22:0], taps[31:23]};
	end

endmodule

// ===== hdl/snow_style_keystream_xor.sv =====
// Top level of the SNOW-style keystream XOR block.
// Depends on snowkx_pkg, snowkx_word_gen and snow_style_keystream_xor_assert.svh.
//
// Usage:
//  - Keys are written over the APB port: key_word_0 at 0x0, key_word_1 at 0x4,
//    key_word_2 at 0x8. pready is tied high; reads return the stored key.
//  - A request on the input channel (in_valid/in_ready) carries command,
//    data_byte and first_of_message. command=0 reloads the 16 shift cells
//    and both FSM registers from the keys and produces no result.
//    command=1 XORs data_byte with the next keystream byte (LSB first) and
//    produces one out_byte on the output channel (out_valid/out_ready).
//  - first_of_message restarts at byte 0 of a freshly generated word.
//  - Registered result: valid in the cycle after acceptance, when out_q is free.
//  - Throughput: one request per cycle while in_ready is high. The whole word
//    step (32-bit add, four S-box lookups, add and rotate) is combinational
//    from the state registers; only the first add and XORs feed the result register.
//  - Output side: a result register plus one skid entry. A request accepted
//    while the output register is stalled goes to the skid entry; in_ready is
//    low while that entry is held, including the cycle it moves up.
//  - Reset (arst_n low): keys, shift cells, FSM registers, current word and
//    byte position go to zero; encrypting before any reload uses that state.
module snow_style_keystream_xor (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	input  logic        first_of_message,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte
);

	`include "snow_style_keystream_xor_assert.svh"

	// key registers
	logic [31:0] key0_q, key1_q, key2_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	// cipher state
	snowkx_pkg::cells_t cells_q;
	logic [31:0]        r1_q, r2_q;
	logic [31:0]        cur_word_q;
	logic [1:0]         byte_pos_q;

	// result buffer: output register plus skid entry
	logic       out_valid_q, skid_valid_q;
	logic [7:0] out_q, skid_q;

	snowkx_pkg::gen_t gen;
	logic             in_acc, enc_acc, reload_acc, pop;
	logic [1:0]       pos_eff;
	logic             fresh;
	logic [31:0]      word_use;
	logic [7:0]       res;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			snowkx_pkg::REG_KEY0: prdata = key0_q;
			snowkx_pkg::REG_KEY1: prdata = key1_q;
			snowkx_pkg::REG_KEY2: prdata = key2_q;
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				snowkx_pkg::REG_KEY0: key0_q <= pwdata;
				snowkx_pkg::REG_KEY1: key1_q <= pwdata;
				snowkx_pkg::REG_KEY2: key2_q <= pwdata;
				default:              ;
			endcase
		end
	end

	// ---------------- keystream step ----------------
	snowkx_word_gen u_word_gen (
		.cells (cells_q),
		.r1    (r1_q),
		.r2    (r2_q),
		.gen   (gen)
	);

	assign in_ready   = !skid_valid_q;
	assign in_acc     = in_valid && in_ready;
	assign enc_acc    = in_acc && (command == snowkx_pkg::CMD_ENCRYPT);
	assign reload_acc = in_acc && (command == snowkx_pkg::CMD_RELOAD);
	assign pop        = out_valid_q && out_ready;

	// first_of_message forces byte 0 of a fresh word
	assign pos_eff  = first_of_message ? 2'd0 : byte_pos_q;
	assign fresh    = (pos_eff == 2'd0);
	assign word_use = fresh ? gen.word : cur_word_q;
	assign res      = data_byte ^ word_use[{pos_eff, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q    <= '0;
			r1_q       <= '0;
			r2_q       <= '0;
			cur_word_q <= '0;
			byte_pos_q <= '0;
		end else if (reload_acc) begin
			// cell i = key0 ^ (i * 0x01010101): i repeated in every byte
			for (int i = 0; i < snowkx_pkg::CELL_COUNT; i++) begin
				cells_q[i] <= key0_q ^ {4{8'(i)}};
			end
			r1_q       <= key1_q;
			r2_q       <= key2_q;
			cur_word_q <= '0;
			byte_pos_q <= '0;
		end else if (enc_acc) begin
			if (fresh) begin
				cells_q    <= {gen.feed, cells_q[snowkx_pkg::CELL_COUNT-1:1]};
				r1_q       <= gen.r1;
				r2_q       <= gen.r2;
				cur_word_q <= gen.word;
			end
			byte_pos_q <= pos_eff + 2'd1;
		end
	end

	// ---------------- result buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q) begin
				out_valid_q <= enc_acc;
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= enc_acc;
				end else begin
					out_valid_q <= enc_acc;
				end
			end else if (enc_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q) begin
			if (enc_acc) begin
				out_q <= res;
			end
		end else if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (enc_acc) begin
					skid_q <= res;
				end
			end else if (enc_acc) begin
				out_q <= res;
			end
		end else if (enc_acc) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_q;

	// ---------------- assertions ----------------
	`SNOWKX_ASSERT(a_skid_behind_out, (!skid_valid_q || out_valid_q), "skid entry without output entry")
	`SNOWKX_ASSERT_NEXT(a_reload_clears, reload_acc, (byte_pos_q == 2'd0 && cur_word_q == 32'd0), "reload left stale word or position")
	`SNOWKX_ASSERT_NEXT(a_first_pos, (enc_acc && first_of_message), (byte_pos_q == 2'd1), "first of message did not restart at byte 0")
	`SNOWKX_ASSERT_NEXT(a_stall_to_skid, (enc_acc && out_valid_q && !out_ready), skid_valid_q, "result lost while output stalled")

endmodule
